>>> rtl/aasm_pkg.sv
// Shared constants, types and the arctangent table for the axis-angle matrix unit.
package aasm_pkg;

    localparam int COORD_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int OUT_W        = 20;

    localparam logic signed [35:0] ONE_Q30   = 36'sd1073741824;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [35:0] OUT_MAX   = 36'sd524287;
    localparam logic signed [35:0] OUT_MIN   = -36'sd524288;

    typedef logic signed [31:0] q30_t;

    // Sideband that travels with every beat down the pipeline.
    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] scale;
        logic               zero;
        logic               ident;
    } side_t;

    // Unit axis leaving the normalizer.
    typedef struct packed {
        q30_t  ux;
        q30_t  uy;
        q30_t  uz;
        side_t side;
    } norm_out_t;

    // Unit axis plus sine and cosine leaving the rotator.
    typedef struct packed {
        q30_t               ux;
        q30_t               uy;
        q30_t               uz;
        logic signed [33:0] sn;
        logic signed [33:0] cs;
        side_t              side;
    } cord_out_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            5'd30:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/aasm_in_if.sv
// Input channel: axis, angle and scale with valid/ready.
interface aasm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
    logic signed [15:0] scale;

    modport source (output valid, axis_x, axis_y, axis_z, angle, scale, input ready);
    modport sink   (input valid, axis_x, axis_y, axis_z, angle, scale, output ready);
endinterface

>>> rtl/aasm_out_if.sv
// Output channel: the nine matrix entries and the zero-axis flag with valid/ready.
interface aasm_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] m00;
    logic signed [19:0] m01;
    logic signed [19:0] m02;
    logic signed [19:0] m10;
    logic signed [19:0] m11;
    logic signed [19:0] m12;
    logic signed [19:0] m20;
    logic signed [19:0] m21;
    logic signed [19:0] m22;
    logic               axis_was_zero;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    axis_was_zero, input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    axis_was_zero, output ready);
endinterface

>>> rtl/aasm_norm.sv
// Axis normalizer: magnitude alignment, sum of squares, pipelined square root and divide.
module aasm_norm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [15:0]    ax,
    input  logic signed [15:0]    ay,
    input  logic signed [15:0]    az,
    input  aasm_pkg::side_t       in_side,
    output logic                  out_valid,
    output aasm_pkg::norm_out_t   out_data
);

    typedef struct packed {
        logic [63:0]     n;
        logic [63:0]     res;
        logic [30:0]     a0;
        logic [30:0]     a1;
        logic [30:0]     a2;
        logic [2:0]      neg;
        aasm_pkg::side_t side;
    } sqrt_t;

    typedef struct packed {
        logic [63:0]     r0;
        logic [63:0]     r1;
        logic [63:0]     r2;
        logic [30:0]     q0;
        logic [30:0]     q1;
        logic [30:0]     q2;
        logic [31:0]     nv;
        logic [2:0]      neg;
        aasm_pkg::side_t side;
    } div_t;

    // Position of the highest set bit.
    function automatic logic [4:0] msb_pos(input logic [16:0] m);
        logic [4:0] p;
        p = 5'd0;
        for (int b = 0; b < 17; b++) begin
            if (m[b]) p = 5'(b);
        end
        return p;
    endfunction

    // Front stage: magnitudes and alignment shift.
    logic [16:0]     a0, a1, a2, mx;
    logic            f_valid_reg;
    logic [16:0]     f_a0_reg, f_a1_reg, f_a2_reg;
    logic [2:0]      f_neg_reg;
    logic [4:0]      f_sh_reg;
    aasm_pkg::side_t f_side_reg;

    always_comb
    begin
        a0 = ax[15] ? 17'(-$signed({ax[15], ax})) : {1'b0, ax};
        a1 = ay[15] ? 17'(-$signed({ay[15], ay})) : {1'b0, ay};
        a2 = az[15] ? 17'(-$signed({az[15], az})) : {1'b0, az};
        mx = (a0 > a1) ? a0 : a1;
        if (a2 > mx) mx = a2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) f_valid_reg <= 1'b0;
        else if (en) f_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_a0_reg   <= a0;
            f_a1_reg   <= a1;
            f_a2_reg   <= a2;
            f_neg_reg  <= {az[15], ay[15], ax[15]};
            f_sh_reg   <= 5'd30 - msb_pos(mx);
            f_side_reg <= in_side;
        end
    end

    // Second stage: aligned components and the sum of their squares.
    logic [63:0] sum_next;
    logic [5:0]  sh2;
    logic        s_valid_reg;
    sqrt_t       s_reg;
    sqrt_t       s_next;

    always_comb
    begin
        sh2 = {f_sh_reg, 1'b0};
        sum_next = (64'(34'(f_a0_reg * f_a0_reg)) << sh2)
                 + (64'(34'(f_a1_reg * f_a1_reg)) << sh2)
                 + (64'(34'(f_a2_reg * f_a2_reg)) << sh2);
        s_next.n    = sum_next;
        s_next.res  = 64'd0;
        s_next.a0   = 31'(47'(f_a0_reg) << f_sh_reg);
        s_next.a1   = 31'(47'(f_a1_reg) << f_sh_reg);
        s_next.a2   = 31'(47'(f_a2_reg) << f_sh_reg);
        s_next.neg  = f_neg_reg;
        s_next.side = f_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s_valid_reg <= 1'b0;
        else if (en) s_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en) s_reg <= s_next;
    end

    // Square root, one result bit per stage.
    sqrt_t                       sq_reg  [aasm_pkg::SQRT_STEPS];
    sqrt_t                       sq_next [aasm_pkg::SQRT_STEPS];
    logic [aasm_pkg::SQRT_STEPS-1:0] sq_v_reg;

    always_comb
    begin
        sqrt_t       cur;
        logic [63:0] bitv;
        logic [63:0] trial;
        for (int k = 0; k < aasm_pkg::SQRT_STEPS; k++)
        begin
            cur   = (k == 0) ? s_reg : sq_reg[(k == 0) ? 0 : k - 1];
            bitv  = 64'd1 << (62 - 2 * k);
            trial = cur.res + bitv;
            sq_next[k] = cur;
            if (cur.n >= trial)
            begin
                sq_next[k].n   = cur.n - trial;
                sq_next[k].res = (cur.res >> 1) + bitv;
            end
            else
            begin
                sq_next[k].res = cur.res >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) sq_v_reg <= '0;
        else if (en) sq_v_reg <= {sq_v_reg[aasm_pkg::SQRT_STEPS-2:0], s_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < aasm_pkg::SQRT_STEPS; k++) sq_reg[k] <= sq_next[k];
        end
    end

    // Rounded division of each aligned component by the root, one quotient bit per stage.
    div_t                           dv_reg  [aasm_pkg::DIV_STEPS];
    div_t                           dv_next [aasm_pkg::DIV_STEPS];
    div_t                           dv_init;
    logic [aasm_pkg::DIV_STEPS-1:0] dv_v_reg;
    sqrt_t                          sq_last;

    always_comb
    begin
        sq_last      = sq_reg[aasm_pkg::SQRT_STEPS-1];
        dv_init.nv   = sq_last.res[31:0];
        dv_init.r0   = 64'({sq_last.a0, 30'b0}) + 64'(sq_last.res[31:1]);
        dv_init.r1   = 64'({sq_last.a1, 30'b0}) + 64'(sq_last.res[31:1]);
        dv_init.r2   = 64'({sq_last.a2, 30'b0}) + 64'(sq_last.res[31:1]);
        dv_init.q0   = '0;
        dv_init.q1   = '0;
        dv_init.q2   = '0;
        dv_init.neg  = sq_last.neg;
        dv_init.side = sq_last.side;
    end

    always_comb
    begin
        div_t        cur;
        logic [63:0] d;
        for (int k = 0; k < aasm_pkg::DIV_STEPS; k++)
        begin
            cur = (k == 0) ? dv_init : dv_reg[(k == 0) ? 0 : k - 1];
            d   = 64'(cur.nv) << (aasm_pkg::DIV_STEPS - 1 - k);
            dv_next[k] = cur;
            if (cur.r0 >= d)
            begin
                dv_next[k].r0 = cur.r0 - d;
                dv_next[k].q0[aasm_pkg::DIV_STEPS-1-k] = 1'b1;
            end
            if (cur.r1 >= d)
            begin
                dv_next[k].r1 = cur.r1 - d;
                dv_next[k].q1[aasm_pkg::DIV_STEPS-1-k] = 1'b1;
            end
            if (cur.r2 >= d)
            begin
                dv_next[k].r2 = cur.r2 - d;
                dv_next[k].q2[aasm_pkg::DIV_STEPS-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dv_v_reg <= '0;
        else if (en) dv_v_reg <= {dv_v_reg[aasm_pkg::DIV_STEPS-2:0],
                                  sq_v_reg[aasm_pkg::SQRT_STEPS-1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < aasm_pkg::DIV_STEPS; k++) dv_reg[k] <= dv_next[k];
        end
    end

    // Restore the signs of the components.
    div_t dv_last;

    always_comb
    begin
        dv_last       = dv_reg[aasm_pkg::DIV_STEPS-1];
        out_valid     = dv_v_reg[aasm_pkg::DIV_STEPS-1];
        out_data.ux   = dv_last.neg[0] ? -$signed({1'b0, dv_last.q0}) : $signed({1'b0, dv_last.q0});
        out_data.uy   = dv_last.neg[1] ? -$signed({1'b0, dv_last.q1}) : $signed({1'b0, dv_last.q1});
        out_data.uz   = dv_last.neg[2] ? -$signed({1'b0, dv_last.q2}) : $signed({1'b0, dv_last.q2});
        out_data.side = dv_last.side;
    end

endmodule

>>> rtl/aasm_cordic.sv
// Pipelined CORDIC rotator giving sine and cosine of the binary angle.
module aasm_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  aasm_pkg::norm_out_t   in_data,
    output logic                  out_valid,
    output aasm_pkg::cord_out_t   out_data
);

    typedef struct packed {
        logic signed [33:0]  x;
        logic signed [33:0]  y;
        logic signed [33:0]  z;
        logic                neg;
        aasm_pkg::norm_out_t u;
    } cst_t;

    // Fold the angle into the right half plane.
    cst_t c0_next;
    cst_t c0_reg;
    logic c0_valid_reg;

    always_comb
    begin
        logic signed [33:0] z0;
        z0 = $signed({{2{in_data.side.angle[15]}}, in_data.side.angle, 16'b0});
        c0_next.x   = aasm_pkg::CORDIC_X0;
        c0_next.y   = '0;
        c0_next.u   = in_data;
        c0_next.neg = 1'b0;
        c0_next.z   = z0;
        if (z0 >= 34'sd1073741824)
        begin
            c0_next.z   = z0 - 34'sd2147483648;
            c0_next.neg = 1'b1;
        end
        else if (z0 < -34'sd1073741824)
        begin
            c0_next.z   = z0 + 34'sd2147483648;
            c0_next.neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c0_valid_reg <= 1'b0;
        else if (en) c0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en) c0_reg <= c0_next;
    end

    // One micro-rotation per stage.
    cst_t                              cr_reg  [aasm_pkg::CORDIC_STEPS];
    cst_t                              cr_next [aasm_pkg::CORDIC_STEPS];
    logic [aasm_pkg::CORDIC_STEPS-1:0] cr_v_reg;

    always_comb
    begin
        cst_t               cur;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] t;
        for (int i = 0; i < aasm_pkg::CORDIC_STEPS; i++)
        begin
            cur = (i == 0) ? c0_reg : cr_reg[(i == 0) ? 0 : i - 1];
            dx  = $signed(cur.y) >>> i;
            dy  = $signed(cur.x) >>> i;
            t   = $signed({2'b00, aasm_pkg::atan_angle(5'(i))});
            cr_next[i] = cur;
            if (!cur.z[33])
            begin
                cr_next[i].x = cur.x - dx;
                cr_next[i].y = cur.y + dy;
                cr_next[i].z = cur.z - t;
            end
            else
            begin
                cr_next[i].x = cur.x + dx;
                cr_next[i].y = cur.y - dy;
                cr_next[i].z = cur.z + t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cr_v_reg <= '0;
        else if (en) cr_v_reg <= {cr_v_reg[aasm_pkg::CORDIC_STEPS-2:0], c0_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < aasm_pkg::CORDIC_STEPS; i++) cr_reg[i] <= cr_next[i];
        end
    end

    // Undo the half-turn fold.
    cst_t cl;

    always_comb
    begin
        cl            = cr_reg[aasm_pkg::CORDIC_STEPS-1];
        out_valid     = cr_v_reg[aasm_pkg::CORDIC_STEPS-1];
        out_data.ux   = cl.u.ux;
        out_data.uy   = cl.u.uy;
        out_data.uz   = cl.u.uz;
        out_data.side = cl.u.side;
        out_data.cs   = cl.neg ? -cl.x : cl.x;
        out_data.sn   = cl.neg ? -cl.y : cl.y;
    end

endmodule

>>> rtl/aasm_matrix.sv
// Rodrigues matrix assembly, scaling and output saturation in four stages.
module aasm_matrix (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  aasm_pkg::cord_out_t   in_data,
    output logic                  out_valid,
    output logic signed [19:0]    m [9],
    output logic                  zero_flag
);

    typedef logic signed [35:0] w_t;

    // Q2.30 product with round to nearest.
    function automatic w_t mulq(input w_t a, input w_t b);
        logic signed [71:0] p;
        p = a * b + 72'sd536870912;
        return p[65:30];
    endfunction

    // Scale, round to Q4.15 and saturate.
    function automatic logic signed [19:0] to_out(input w_t r, input logic signed [15:0] sc);
        logic signed [51:0] p;
        logic signed [51:0] q;
        p = r * sc + 52'sd67108864;
        q = p >>> 27;
        if (q > 52'(aasm_pkg::OUT_MAX)) q = 52'(aasm_pkg::OUT_MAX);
        if (q < 52'(aasm_pkg::OUT_MIN)) q = 52'(aasm_pkg::OUT_MIN);
        return q[19:0];
    endfunction

    // Stage 1: axis outer products, sine terms and one minus cosine.
    logic            v1_reg;
    w_t              xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    w_t              sx_reg, sy_reg, sz_reg, omc_reg;
    aasm_pkg::side_t sd1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (en) v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg  <= mulq(36'(in_data.ux), 36'(in_data.ux));
            yy_reg  <= mulq(36'(in_data.uy), 36'(in_data.uy));
            zz_reg  <= mulq(36'(in_data.uz), 36'(in_data.uz));
            xy_reg  <= mulq(36'(in_data.ux), 36'(in_data.uy));
            xz_reg  <= mulq(36'(in_data.ux), 36'(in_data.uz));
            yz_reg  <= mulq(36'(in_data.uy), 36'(in_data.uz));
            sx_reg  <= mulq(36'(in_data.sn), 36'(in_data.ux));
            sy_reg  <= mulq(36'(in_data.sn), 36'(in_data.uy));
            sz_reg  <= mulq(36'(in_data.sn), 36'(in_data.uz));
            omc_reg <= aasm_pkg::ONE_Q30 - 36'(in_data.cs);
            sd1_reg <= in_data.side;
        end
    end

    // Stage 2: weight the symmetric part by one minus cosine.
    logic            v2_reg;
    w_t              dx_reg, dy_reg, dz_reg, gxy_reg, gxz_reg, gyz_reg;
    w_t              sx2_reg, sy2_reg, sz2_reg;
    aasm_pkg::side_t sd2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= mulq(omc_reg, xx_reg - aasm_pkg::ONE_Q30);
            dy_reg  <= mulq(omc_reg, yy_reg - aasm_pkg::ONE_Q30);
            dz_reg  <= mulq(omc_reg, zz_reg - aasm_pkg::ONE_Q30);
            gxy_reg <= mulq(omc_reg, xy_reg);
            gxz_reg <= mulq(omc_reg, xz_reg);
            gyz_reg <= mulq(omc_reg, yz_reg);
            sx2_reg <= sx_reg;
            sy2_reg <= sy_reg;
            sz2_reg <= sz_reg;
            sd2_reg <= sd1_reg;
        end
    end

    // Stage 3: the nine rotation entries, identity for a zero axis or angle.
    logic            v3_reg;
    w_t              r_reg [9];
    w_t              r_next [9];
    aasm_pkg::side_t sd3_reg;

    always_comb
    begin
        r_next[0] = aasm_pkg::ONE_Q30 + dx_reg;
        r_next[4] = aasm_pkg::ONE_Q30 + dy_reg;
        r_next[8] = aasm_pkg::ONE_Q30 + dz_reg;
        r_next[1] = gxy_reg - sz2_reg;
        r_next[3] = gxy_reg + sz2_reg;
        r_next[2] = gxz_reg + sy2_reg;
        r_next[6] = gxz_reg - sy2_reg;
        r_next[5] = gyz_reg - sx2_reg;
        r_next[7] = gyz_reg + sx2_reg;
        if (sd2_reg.ident)
        begin
            for (int i = 0; i < 9; i++)
                r_next[i] = (i % 4 == 0) ? aasm_pkg::ONE_Q30 : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++) r_reg[i] <= r_next[i];
            sd3_reg <= sd2_reg;
        end
    end

    // Stage 4: scale and saturate into the output register.
    logic               v4_reg;
    logic signed [19:0] m_reg [9];
    logic               z4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++) m_reg[i] <= to_out(r_reg[i], sd3_reg.scale);
            z4_reg <= sd3_reg.zero;
        end
    end

    assign out_valid = v4_reg;
    assign m         = m_reg;
    assign zero_flag = z4_reg;

endmodule

>>> rtl/axis_angle_similitude_matrix_unit.sv
// Top level of the axis-angle similitude matrix unit.
//
//  Channel  Dir  Handshake     Beat contents
//  item     in   valid/ready   axis_x, axis_y, axis_z, angle, scale
//  result   out  valid/ready   m00..m22 (Q4.15), axis_was_zero
//
// One beat enters per cycle unless the result is held; each input beat that is accepted
// passes through 86 register stages (2 align, 32 square root, 31 divide,
// 17 CORDIC, 4 matrix and scale stages).
// The depth is set by the bit-per-stage square root and divider.
// Reset clears only the valid bits of the stages.
// When the result is held, the whole pipeline holds and item.ready drops.
module axis_angle_similitude_matrix_unit (
    input  logic        clk,
    input  logic        rst_n,
    aasm_in_if.sink     item,
    aasm_out_if.source  result
);

    logic                en;
    aasm_pkg::side_t     side;
    logic                nm_valid;
    aasm_pkg::norm_out_t nm_data;
    logic                co_valid;
    aasm_pkg::cord_out_t co_data;
    logic                mx_valid;
    logic signed [19:0]  mx_m [9];
    logic                mx_zero;

    // Global advance: move when the output register is empty or being taken.
    assign en         = !mx_valid || result.ready;
    assign item.ready = en;

    // Identity cases flagged at entry.
    always_comb
    begin
        side.angle = item.angle;
        side.scale = item.scale;
        side.zero  = (item.axis_x == '0) && (item.axis_y == '0) && (item.axis_z == '0);
        side.ident = side.zero || (item.angle == '0);
    end

    aasm_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item.valid),
        .ax        (item.axis_x),
        .ay        (item.axis_y),
        .az        (item.axis_z),
        .in_side   (side),
        .out_valid (nm_valid),
        .out_data  (nm_data)
    );

    aasm_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid),
        .in_data   (nm_data),
        .out_valid (co_valid),
        .out_data  (co_data)
    );

    aasm_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (co_valid),
        .in_data   (co_data),
        .out_valid (mx_valid),
        .m         (mx_m),
        .zero_flag (mx_zero)
    );

    // Result beat.
    assign result.valid         = mx_valid;
    assign result.m00           = mx_m[0];
    assign result.m01           = mx_m[1];
    assign result.m02           = mx_m[2];
    assign result.m10           = mx_m[3];
    assign result.m11           = mx_m[4];
    assign result.m12           = mx_m[5];
    assign result.m20           = mx_m[6];
    assign result.m21           = mx_m[7];
    assign result.m22           = mx_m[8];
    assign result.axis_was_zero = mx_zero;

    // A taken result always frees the input side.
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> item.ready)
        else $error("input not ready while result is being taken");

    // A zero axis yields a scaled identity: off-diagonal entries are zero.
    a_zero_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.axis_was_zero) |->
        (result.m01 == '0 && result.m02 == '0 && result.m10 == '0 &&
         result.m12 == '0 && result.m20 == '0 && result.m21 == '0))
        else $error("zero axis gave nonzero off-diagonal entries");

    // A zero axis yields equal diagonal entries.
    a_zero_diag: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.axis_was_zero) |->
        (result.m00 == result.m11 && result.m11 == result.m22))
        else $error("zero axis gave unequal diagonal entries");

    // A held result stays valid until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid && !item.ready) || result.ready)
        else $error("held result dropped");

endmodule
